/* design/tsd_pkg.sv */
// Package with the shared constants, types and codes of the tick slot dispatcher.
`default_nettype none
package tsd_pkg;

  localparam int NUM_SLOTS_DEF      = 8;
  localparam int TICK_PERIOD_US_DEF = 1000;
  localparam int US_PER_MS          = 1000;

  localparam int MODE_W   = 2;
  localparam int CLIENT_W = 16;
  localparam int RATE_W   = 32;
  localparam int SLOT_W   = 3;
  localparam int FIRE_W   = 8;
  localparam int TIME_W   = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_REQUEST = 2'd1,
    MODE_CANCEL  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // One slot table entry as kept in the slot memory.
  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic [RATE_W-1:0]   rate;
    logic [RATE_W-1:0]   count;
  } slot_entry_t;

endpackage
`default_nettype wire

/* design/tsd_if.sv */
// Valid/ready channel interfaces for the dispatcher's items and results.
`default_nettype none
interface tsd_item_if;
  import tsd_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [CLIENT_W-1:0] client_id;
  logic [RATE_W-1:0]   rate;

  modport source (output valid, output mode, output client_id, output rate, input ready);
  modport sink   (input valid, input mode, input client_id, input rate, output ready);
endinterface

interface tsd_result_if;
  import tsd_pkg::*;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [SLOT_W-1:0] granted_slot;
  logic [FIRE_W-1:0] fire_mask;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, output accepted, output granted_slot, output fire_mask,
                  output time_ms, input ready);
  modport sink   (input valid, input accepted, input granted_slot, input fire_mask,
                  input time_ms, output ready);
endinterface
`default_nettype wire

/* design/tsd_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module tsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/periodic_tick_slot_dispatcher_top.sv */
// Top level of the periodic tick slot dispatcher.
`default_nettype none
// The dispatcher keeps a table of NUM_SLOTS periodic client slots. Every transaction on the
// item channel yields exactly one transaction on the result channel. A tick advances the
// millisecond time by TICK_PERIOD_US / 1000 and bumps the count of every occupied slot;
// slots whose count reaches their rate report a bit in fire_mask and restart at zero.
// A request takes the lowest free slot (refused when the table is full, when the client
// id is zero, or when enable_requests is low), and a cancel frees all slots of a client.
// The slot entries live in one RAM that a single compare/increment unit visits one slot
// per cycle, so the block takes no new item before it is through with the last one:
// item.ready drops at the acceptance and returns only once the sweep, the drain step
// and the loading of the result are done, and that loading waits while a previous
// result waits on result.ready. The slot sweep through the RAM read port sets the pace.
// After reset all slots are free and no clearing pass is needed: occupancy is held in
// one flip-flop per slot. enable_requests resets to one and is written through cfg_we.
module periodic_tick_slot_dispatcher_top #(
  parameter int NUM_SLOTS      = tsd_pkg::NUM_SLOTS_DEF,
  parameter int TICK_PERIOD_US = tsd_pkg::TICK_PERIOD_US_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata,
  tsd_item_if.sink    item,
  tsd_result_if.source result
);

  import tsd_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int EXT_W = IDX_W + SLOT_W;
  localparam logic [TIME_W-1:0] TIME_STEP = TIME_W'(TICK_PERIOD_US / US_PER_MS);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_SLOTS - 1);

  // Control state.
  state_t               state, state_next;
  logic                 enable_requests;
  logic [NUM_SLOTS-1:0] slot_used;
  logic                 res_valid;

  // Item held for the sweep.
  logic [MODE_W-1:0]   cur_mode;
  logic [CLIENT_W-1:0] cur_client;
  logic [RATE_W-1:0]   cur_rate;

  // Sweep counters: idx addresses the RAM read, proc_idx is the slot whose data is back.
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] proc_idx;
  logic             proc_valid;

  // Per-item results being gathered.
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic [FIRE_W-1:0] fire;
  logic [TIME_W-1:0] time_counter;

  // Shared slot unit.
  slot_entry_t       rd_entry, wr_entry;
  logic              wr_en;
  logic              used_set, used_clr, fire_hit, claim;
  logic [RATE_W-1:0] count_inc;
  logic [EXT_W-1:0]  proc_ext, found_ext;

  logic item_fire, load_result;

  assign item_fire   = item.valid && item.ready;
  assign item.ready  = (state == ST_IDLE);
  assign load_result = (state == ST_DONE) && (!res_valid || result.ready);

  tsd_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (NUM_SLOTS),
    .ADDR_W(IDX_W)
  ) u_slot_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(proc_idx),
    .wdata(wr_entry),
    .raddr(idx),
    .rdata(rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (item_fire) state_next = ST_SWEEP;
      ST_SWEEP: if (idx == LAST_IDX) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE:  if (load_result) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // The slot unit: one increment and compare for ticks, one id compare for cancels and
  // a free-slot check for requests, applied to the slot whose entry just came back.
  always_comb begin
    wr_en     = 1'b0;
    wr_entry  = rd_entry;
    used_set  = 1'b0;
    used_clr  = 1'b0;
    fire_hit  = 1'b0;
    claim     = 1'b0;
    count_inc = rd_entry.count + RATE_W'(1);
    if (proc_valid) begin
      case (cur_mode)
        MODE_TICK: begin
          if (slot_used[proc_idx]) begin
            wr_en = 1'b1;
            if (count_inc == rd_entry.rate) begin
              fire_hit       = 1'b1;
              wr_entry.count = '0;
            end else begin
              wr_entry.count = count_inc;
            end
          end
        end
        MODE_REQUEST: begin
          if (!found && !slot_used[proc_idx] && enable_requests && (cur_client != '0)) begin
            claim           = 1'b1;
            used_set        = 1'b1;
            wr_en           = 1'b1;
            wr_entry.client = cur_client;
            wr_entry.rate   = cur_rate;
            wr_entry.count  = '0;
          end
        end
        MODE_CANCEL: begin
          if (slot_used[proc_idx] && (rd_entry.client == cur_client)) begin
            used_clr = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign proc_ext  = EXT_W'(proc_idx);
  assign found_ext = EXT_W'(found_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_requests <= 1'b1;
      slot_used       <= '0;
      res_valid       <= 1'b0;
      proc_valid      <= 1'b0;
      time_counter    <= '0;
      found           <= 1'b0;
      idx             <= '0;
    end else begin
      if (cfg_we) begin
        enable_requests <= cfg_wdata;
      end

      if (item_fire) begin
        cur_mode   <= item.mode;
        cur_client <= item.client_id;
        cur_rate   <= item.rate;
        idx        <= '0;
        found      <= 1'b0;
        fire       <= '0;
        if (item.mode == MODE_TICK) begin
          time_counter <= time_counter + TIME_STEP;
        end
      end else if (state == ST_SWEEP && idx != LAST_IDX) begin
        idx <= idx + IDX_W'(1);
      end

      proc_valid <= (state == ST_SWEEP);
      proc_idx   <= idx;

      if (used_set) begin
        slot_used[proc_idx] <= 1'b1;
      end
      if (used_clr) begin
        slot_used[proc_idx] <= 1'b0;
      end
      if (claim) begin
        found     <= 1'b1;
        found_idx <= proc_idx;
      end
      // Slots above the eighth still count and wrap but have no fire bit.
      if (fire_hit && (proc_ext < EXT_W'(FIRE_W))) begin
        fire[proc_ext[SLOT_W-1:0]] <= 1'b1;
      end

      if (load_result) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result register: filled once per item, held until the result transaction.
  always_ff @(posedge clk) begin
    if (load_result) begin
      result.accepted     <= found;
      result.granted_slot <= found ? found_ext[SLOT_W-1:0] : '0;
      result.fire_mask    <= fire;
      result.time_ms      <= time_counter;
    end
  end

  assign result.valid = res_valid;

endmodule
`default_nettype wire
